[rtl/blocked_bitmap_index_allocator_defines.svh]
// Assertion macros for the blocked bitmap index allocator.
`ifndef BLOCKED_BITMAP_INDEX_ALLOCATOR_DEFINES_SVH
`define BLOCKED_BITMAP_INDEX_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BBIA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define BBIA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/bbia_pkg.sv]
// Shared types and constants for the blocked bitmap index allocator.
`timescale 1ns / 1ps

package bbia_pkg;

  localparam int CMD_W     = 2;
  localparam int BLOCK_W   = 4;
  localparam int INDEX_W   = 10;
  localparam int POS_MAX_W = 6;
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 3;

  // register index, taken from paddr[2]
  localparam logic REG_ROUND_ROBIN = 1'b0;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_t;

  typedef struct packed {
    logic                 found;
    logic [POS_MAX_W-1:0] pos;
  } hit_t;

endpackage

[rtl/bbia_scan.sv]
// First-free search over one block bitmap, starting at a given position with wrap.
`timescale 1ns / 1ps

module bbia_scan import bbia_pkg::*; #(
  parameter int ENTRIES_PER_BLOCK = 64,
  localparam int PW = $clog2(ENTRIES_PER_BLOCK)
) (
  input  logic [ENTRIES_PER_BLOCK-1:0] free_bits,
  input  logic [PW-1:0]                start,
  output hit_t                         hit
);

  logic [ENTRIES_PER_BLOCK-1:0] above;
  logic [ENTRIES_PER_BLOCK-1:0] pick;
  logic [ENTRIES_PER_BLOCK-1:0] first;
  logic [POS_MAX_W-1:0]         enc;

  always_comb begin
    for (int i = 0; i < ENTRIES_PER_BLOCK; i++) begin
      above[i] = free_bits[i] && (PW'(i) >= start);
    end
  end

  // wrap to the bottom when nothing is free at or above start
  assign pick  = (|above) ? above : free_bits;
  assign first = pick & (~pick + 1'b1);

  always_comb begin
    enc = '0;
    for (int i = 0; i < ENTRIES_PER_BLOCK; i++) begin
      if (first[i]) begin
        enc = enc | POS_MAX_W'(i);
      end
    end
  end

  assign hit.found = |free_bits;
  assign hit.pos   = enc;

endmodule

[rtl/blocked_bitmap_index_allocator.sv]
// Top level of the blocked bitmap index allocator.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid/in_stall) carries command, block and entry_index.
//   Allocate takes the first free entry of a block (from zero, or after the
//   last used position with wrap when round_robin is set) and returns its
//   global index; free clears the bit of a global index and reports whether
//   its block is now empty; query tests the bit of a global index.
//   Output channel (out_valid/out_stall) carries ok, index and block_empty,
//   one result transaction per input transaction, in order.
//   The block entry is read into a register on accept, and the result is
//   registered from the modify stage. A new transaction is not taken while
//   one is in the modify stage; its read and write-back share the memory.
//   A result waiting under out_stall does not block the next input; the
//   following result holds in the modify stage until the output is free.
//   Reset: round_robin clears at once; then a clearing pass zeroes the
//   block memory with in_stall high, APB writes working. round_robin is
//   written over APB at address 0 by the user only while idle; not enforced.

`include "blocked_bitmap_index_allocator_defines.svh"

module blocked_bitmap_index_allocator import bbia_pkg::*; #(
  parameter int ENTRIES_PER_BLOCK = 64,
  parameter int NUM_BLOCKS        = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [CMD_W-1:0]   command,
  input  logic [BLOCK_W-1:0] block,
  input  logic [INDEX_W-1:0] entry_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               ok,
  output logic [INDEX_W-1:0] index,
  output logic               block_empty,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  localparam int PW     = $clog2(ENTRIES_PER_BLOCK);
  localparam int AW     = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int DW     = ENTRIES_PER_BLOCK + PW;
  localparam int SHIFT  = 20;
  localparam int RECIP  = ((2 ** SHIFT) + ENTRIES_PER_BLOCK - 1) / ENTRIES_PER_BLOCK;
  localparam int PROD_W = INDEX_W + SHIFT + 1;

  localparam logic [SHIFT:0]         RECIP_V = (SHIFT + 1)'(RECIP);
  localparam logic [INDEX_W-1:0]     EPB_V   = INDEX_W'(ENTRIES_PER_BLOCK);
  localparam logic [PW:0]            EPB_P   = (PW + 1)'(ENTRIES_PER_BLOCK);
  localparam logic [AW-1:0]          LAST_BLK = AW'(NUM_BLOCKS - 1);

  // configuration
  logic round_robin;
  logic apb_wr;

  // control
  logic clearing;
  logic [AW-1:0] clr_addr;
  logic busy;
  logic accept;
  logic done;

  // block memory: {last position, occupancy bitmap}
  logic [DW-1:0] mem [NUM_BLOCKS];
  logic          mem_re;
  logic          mem_we;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [DW-1:0] wr_data;
  logic [DW-1:0] rd_data;

  // accept-side decode
  logic [PROD_W-1:0]  prod;
  logic [INDEX_W-1:0] quot;
  logic               in_range;

  // registered item
  cmd_t               cur_cmd;
  logic [INDEX_W-1:0] cur_index;
  logic [INDEX_W-1:0] cur_quot;
  logic [INDEX_W-1:0] cur_base;
  logic [AW-1:0]      cur_addr;
  logic               cur_in_range;

  // modify stage
  logic [ENTRIES_PER_BLOCK-1:0] bits;
  logic [PW-1:0]                last_pos;
  logic [PW:0]                  nxt_pos;
  logic [PW-1:0]                start;
  logic [INDEX_W-1:0]           qd;
  logic [INDEX_W-1:0]           rem_full;
  logic [PW-1:0]                rem;
  hit_t                         hit;
  logic [PW-1:0]                alloc_pos;
  logic [ENTRIES_PER_BLOCK-1:0] set_bits;
  logic [ENTRIES_PER_BLOCK-1:0] clr_bits;
  logic                         alloc_ok;
  logic                         upd;
  logic [DW-1:0]                upd_data;
  logic                         res_ok;
  logic [INDEX_W-1:0]           res_index;
  logic                         res_empty;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign apb_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_ROUND_ROBIN) ? {{(DATA_W-1){1'b0}}, round_robin} : '0;

  // ---------------- handshake ----------------
  assign in_stall = clearing || busy;
  assign accept   = in_valid && !in_stall;
  assign done     = busy && (!out_valid || !out_stall);

  // exact quotient by reciprocal for 10-bit numerators
  assign prod = PROD_W'(entry_index * RECIP_V);
  assign quot = prod[SHIFT +: INDEX_W];

  always_comb begin
    if (cmd_t'(command) == CMD_ALLOC) begin
      in_range = {{(32-BLOCK_W){1'b0}}, block} < 32'(NUM_BLOCKS);
      rd_addr  = AW'(block);
    end else begin
      in_range = {{(32-INDEX_W){1'b0}}, quot} < 32'(NUM_BLOCKS);
      rd_addr  = AW'(quot);
    end
  end

  // ---------------- block memory ----------------
  assign mem_re  = accept;
  assign mem_we  = clearing || (done && upd);
  assign wr_addr = clearing ? clr_addr : cur_addr;
  assign wr_data = clearing ? '0 : upd_data;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (mem_re) begin
      rd_data <= mem[rd_addr];
    end
  end

  // ---------------- modify stage ----------------
  assign bits     = rd_data[ENTRIES_PER_BLOCK-1:0];
  assign last_pos = rd_data[DW-1:ENTRIES_PER_BLOCK];
  assign nxt_pos  = {1'b0, last_pos} + 1'b1;
  assign start    = (round_robin && (nxt_pos < EPB_P)) ? nxt_pos[PW-1:0] : '0;

  assign qd       = INDEX_W'(cur_quot * EPB_V);
  assign rem_full = cur_index - qd;
  assign rem      = rem_full[PW-1:0];

  bbia_scan #(
    .ENTRIES_PER_BLOCK(ENTRIES_PER_BLOCK)
  ) u_scan (
    .free_bits(~bits),
    .start    (start),
    .hit      (hit)
  );

  assign alloc_pos = hit.pos[PW-1:0];
  assign set_bits  = bits | ({{(ENTRIES_PER_BLOCK-1){1'b0}}, 1'b1} << alloc_pos);
  assign clr_bits  = bits & ~({{(ENTRIES_PER_BLOCK-1){1'b0}}, 1'b1} << rem);
  assign alloc_ok  = cur_in_range && hit.found;

  always_comb begin
    upd       = 1'b0;
    upd_data  = rd_data;
    res_ok    = 1'b0;
    res_index = '0;
    res_empty = 1'b0;
    case (cur_cmd)
      CMD_ALLOC: begin
        if (alloc_ok) begin
          upd       = 1'b1;
          upd_data  = {(round_robin ? alloc_pos : last_pos), set_bits};
          res_ok    = 1'b1;
          res_index = cur_base + INDEX_W'(alloc_pos);
        end
      end
      CMD_FREE: begin
        res_ok = 1'b1;
        if (cur_in_range) begin
          upd       = 1'b1;
          upd_data  = {last_pos, clr_bits};
          res_empty = (clr_bits == '0);
        end
      end
      CMD_QUERY: begin
        res_ok = cur_in_range && bits[rem];
      end
      default: begin
        upd = 1'b0;
      end
    endcase
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      round_robin <= 1'b0;
      clearing    <= 1'b1;
      clr_addr    <= '0;
      busy        <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (apb_wr && (paddr[2] == REG_ROUND_ROBIN)) begin
        round_robin <= pwdata[0];
      end
      if (clearing) begin
        if (clr_addr == LAST_BLK) begin
          clearing <= 1'b0;
        end else begin
          clr_addr <= clr_addr + 1'b1;
        end
      end
      if (accept) begin
        busy <= 1'b1;
      end else if (done) begin
        busy <= 1'b0;
      end
      if (done) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_cmd      <= cmd_t'(command);
      cur_index    <= entry_index;
      cur_quot     <= quot;
      cur_base     <= INDEX_W'({{(INDEX_W-BLOCK_W){1'b0}}, block} * EPB_V);
      cur_addr     <= rd_addr;
      cur_in_range <= in_range;
    end
    if (done) begin
      ok          <= res_ok;
      index       <= res_index;
      block_empty <= res_empty;
    end
  end

  // ---------------- assertions ----------------
  `BBIA_ASSERT_NXT(a_accept_busy, accept, busy, "accepted item did not enter the modify stage")
  `BBIA_ASSERT_IMP(a_port_share, mem_re, !mem_we, "block memory read and write in one cycle")
  `BBIA_ASSERT_NXT(a_done_result, done, !busy && out_valid, "finished item left no result")
  `BBIA_ASSERT_IMP(a_clear_quiet, clearing, !busy && !out_valid, "item in flight during clearing")

endmodule

[tb/testbench.sv]
// Self-checking testbench for the blocked bitmap index allocator.
`timescale 1ns / 1ps

module testbench;
  import bbia_pkg::*;

  localparam int ENTRIES      = 64;
  localparam int BLOCKS       = 16;
  localparam int IDLE_PCT     = 11;
  localparam int QUIET_LIMIT  = 3000;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 4;

  localparam logic [CMD_W-1:0]  CMD_RESERVED     = 2'd3;
  localparam logic [ADDR_W-1:0] ADDR_ROUND_ROBIN = {REG_ROUND_ROBIN, 2'b00};

  typedef struct packed {
    logic               ok;
    logic [INDEX_W-1:0] index;
    logic               block_empty;
  } response_t;

  logic               clk         = 1'b0;
  logic               rst         = 1'b1;
  logic               in_valid    = 1'b0;
  logic               in_stall;
  logic [CMD_W-1:0]   command     = '0;
  logic [BLOCK_W-1:0] block       = '0;
  logic [INDEX_W-1:0] entry_index = '0;
  logic               out_valid;
  logic               out_stall   = 1'b0;
  logic               ok;
  logic [INDEX_W-1:0] index;
  logic               block_empty;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [ADDR_W-1:0]  paddr       = '0;
  logic [DATA_W-1:0]  pwdata      = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  // allocator shadow state
  logic [ENTRIES-1:0]   occ_map [BLOCKS];
  logic [POS_MAX_W-1:0] rr_last [BLOCKS];
  logic                 rr_mode;

  response_t          pending_responses[$];
  logic [INDEX_W-1:0] live_indices[$];
  int                 n_fail    = 0;
  int                 quiet     = 0;
  int                 hold_left = 0;
  logic               hold_req  = 1'b0;
  logic               no_idle   = 1'b0;

  blocked_bitmap_index_allocator #(
    .ENTRIES_PER_BLOCK(ENTRIES),
    .NUM_BLOCKS       (BLOCKS)
  ) dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int first_clear_bit(input logic [ENTRIES-1:0] bits, input int start);
    for (int p = start; p < ENTRIES; p++)
      if (!bits[p]) return p;
    return ENTRIES;
  endfunction

  function automatic response_t predict_response(input logic [CMD_W-1:0] cmd,
                                                 input logic [BLOCK_W-1:0] blk,
                                                 input logic [INDEX_W-1:0] gidx);
    response_t r;
    int start, pos, eblk, epos;
    r = '0;
    eblk = int'(gidx) / ENTRIES;
    epos = int'(gidx) % ENTRIES;
    case (cmd)
      CMD_ALLOC: begin
        if (int'(blk) < BLOCKS) begin
          start = 0;
          if (rr_mode) begin
            start = int'(rr_last[blk]) + 1;
            if (start >= ENTRIES) start = 0;
          end
          pos = first_clear_bit(occ_map[blk], start);
          // round-robin wraps back to entry zero
          if (rr_mode && pos >= ENTRIES) pos = first_clear_bit(occ_map[blk], 0);
          if (pos < ENTRIES) begin
            occ_map[blk][pos] = 1'b1;
            if (rr_mode) rr_last[blk] = pos[POS_MAX_W-1:0];
            r.ok = 1'b1;
            r.index = INDEX_W'(int'(blk) * ENTRIES + pos);
          end
        end
      end
      CMD_FREE: begin
        r.ok = 1'b1;
        if (eblk < BLOCKS) begin
          occ_map[eblk][epos] = 1'b0;
          r.block_empty = (occ_map[eblk] == '0);
        end
      end
      CMD_QUERY: begin
        if (eblk < BLOCKS) r.ok = occ_map[eblk][epos];
      end
      default: ;
    endcase
    return r;
  endfunction

  // one input transaction; called right after a rising edge
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [BLOCK_W-1:0] blk,
                           input logic [INDEX_W-1:0] gidx);
    response_t r;
    in_valid    <= 1'b1;
    command     <= cmd;
    block       <= blk;
    entry_index <= gidx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = predict_response(cmd, blk, gidx);
    pending_responses.push_back(r);
    if (cmd == CMD_ALLOC && r.ok) live_indices.push_back(r.index);
    if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 30);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_round_robin(input logic val);
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_ROUND_ROBIN;
    pwdata  <= ($urandom() & 32'hFFFF_FFFE) | DATA_W'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rr_mode = val;
    // read back
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[0] !== rr_mode) begin
      $error("round_robin mismatch: expected %0d actual %0d", rr_mode, prdata[0]);
      n_fail++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [BLOCK_W-1:0] pick_block();
    if ($urandom_range(99) < 70) return BLOCK_W'($urandom_range(3));
    return BLOCK_W'($urandom_range(BLOCKS - 1));
  endfunction

  function automatic logic [INDEX_W-1:0] pick_live(input bit remove);
    int k;
    logic [INDEX_W-1:0] v;
    if (live_indices.size() == 0) return INDEX_W'($urandom_range(1023));
    k = $urandom_range(live_indices.size() - 1);
    v = live_indices[k];
    if (remove) live_indices.delete(k);
    return v;
  endfunction

  // mostly well-formed alloc/free/query sequences, some raw noise
  task automatic run_random(input int n_items);
    int sent, kind, len;
    logic [BLOCK_W-1:0] blk;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(99);
      len  = $urandom_range(1, 8);
      if (kind < 35) begin
        blk = pick_block();
        if ($urandom_range(9) == 0) len = $urandom_range(40, 70);
        repeat (len) send_item(CMD_ALLOC, blk, INDEX_W'($urandom_range(1023)));
      end else if (kind < 65) begin
        repeat (len)
          send_item(CMD_FREE, BLOCK_W'($urandom_range(15)), pick_live(1'b1));
      end else if (kind < 80) begin
        repeat (len)
          send_item(CMD_QUERY, BLOCK_W'($urandom_range(15)),
                    ($urandom_range(1) == 1) ? pick_live(1'b0)
                                             : INDEX_W'($urandom_range(1023)));
      end else begin
        repeat (len)
          send_item(CMD_W'($urandom_range(3)), BLOCK_W'($urandom_range(15)),
                    INDEX_W'($urandom_range(1023)));
      end
      sent += len;
    end
  endtask

  task automatic test_first_fit();
    send_item(CMD_QUERY, 4'd0, 10'd0);
    send_item(CMD_QUERY, 4'd15, 10'd1023);
    send_item(CMD_FREE, 4'd15, 10'd1023);          // free of unused entry, empty block
    send_item(CMD_RESERVED, 4'd15, 10'd1023);
    send_item(CMD_ALLOC, 4'd15, 10'd1023);
    send_item(CMD_QUERY, 4'd0, 10'd960);
    send_item(CMD_ALLOC, 4'd15, 10'd0);
    send_item(CMD_FREE, 4'd0, 10'd960);
    send_item(CMD_ALLOC, 4'd15, 10'd0);            // refills the hole at zero
    send_item(CMD_FREE, 4'd0, 10'd960);
    send_item(CMD_FREE, 4'd0, 10'd961);
    send_item(CMD_FREE, 4'd0, 10'd961);
    send_item(CMD_ALLOC, 4'd0, 10'd0);
    send_item(CMD_FREE, 4'd0, 10'd0);
    live_indices.delete();
  endtask

  task automatic test_round_robin();
    write_round_robin(1'b1);
    send_item(CMD_ALLOC, 4'd7, 10'd0);
    send_item(CMD_ALLOC, 4'd7, 10'd0);
    send_item(CMD_FREE, 4'd7, 10'd449);
    send_item(CMD_ALLOC, 4'd7, 10'd0);             // skips the freed entry
    send_item(CMD_FREE, 4'd7, 10'd450);
    send_item(CMD_FREE, 4'd7, 10'd451);
    send_item(CMD_ALLOC, 4'd7, 10'd0);
    write_round_robin(1'b0);
  endtask

  task automatic test_streaming();
    write_round_robin(1'b1);
    no_idle <= 1'b1;
    run_random(150);
    no_idle <= 1'b0;
  endtask

  task automatic test_backpressure();
    hold_req <= 1'b1;
    run_random(40);
  endtask

  task automatic test_random_mix();
    write_round_robin(1'b0);
    run_random(350);
    write_round_robin(1'b1);
    run_random(350);
    write_round_robin(1'b0);
    run_random(250);
  endtask

  // result checker and output stall
  always @(posedge clk) begin : rx_side
    response_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_responses.size() == 0) begin
        $error("result transaction with none expected");
        n_fail++;
      end else begin
        want = pending_responses.pop_front();
        if (ok !== want.ok) begin
          $error("ok mismatch: expected %0d actual %0d", want.ok, ok);
          n_fail++;
        end
        if (index !== want.index) begin
          $error("index mismatch: expected %0d actual %0d", want.index, index);
          n_fail++;
        end
        if (block_empty !== want.block_empty) begin
          $error("block_empty mismatch: expected %0d actual %0d", want.block_empty,
                 block_empty);
          n_fail++;
        end
      end
    end
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req <= 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("FAIL blocked_bitmap_index_allocator");
        $finish;
      end
    end
  end

  initial begin
    foreach (occ_map[i]) begin
      occ_map[i] = '0;
      rr_last[i] = '0;
    end
    rr_mode = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_first_fit();
    test_round_robin();
    test_streaming();
    test_backpressure();
    test_random_mix();
    wait_idle();
    if (n_fail == 0) begin
      $display("PASS blocked_bitmap_index_allocator");
    end else begin
      $display("FAIL blocked_bitmap_index_allocator");
    end
    $finish;
  end

endmodule
